FILE: hdl/dac_voltage_code_converter_unit_macros.svh
// Assertion macros for the DAC voltage/code converter.
// Included by the top level; needs nothing else.
`ifndef DAC_VOLTAGE_CODE_CONVERTER_UNIT_MACROS_SVH
`define DAC_VOLTAGE_CODE_CONVERTER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked at every rising clock edge out of reset.
`define DVC_ASSERT_NOW(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("dvc assertion failed");
// Next-cycle implication.
`define DVC_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("dvc assertion failed");
`else
`define DVC_ASSERT_NOW(lbl, ck, rn, ante, cons)
`define DVC_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

FILE: hdl/dvc_pkg.sv
// Package of the DAC voltage/code converter: range table, register indexes,
// pipeline word type. Depends on nothing.
`default_nettype none
package dvc_pkg;

	localparam int DIV_STAGES = 16;
	localparam int FRONT_STAGES = 6;
	localparam int NUM_STAGES = FRONT_STAGES + DIV_STAGES + 1;

	// floor(x * RECIP10 / 2^19) is x/10 or one below it for the widths used here.
	localparam logic [15:0] RECIP10 = 16'd52428;

	typedef enum logic [1:0] {
		REG_OUTPUT_RANGE = 2'd0,
		REG_VREF_MV      = 2'd1,
		REG_RES_BITS     = 2'd2
	} reg_idx_t;

	localparam logic [6:0] GAIN_TAB [8] = '{7'd80, 7'd40, 7'd40, 7'd20,
		7'd40, 7'd24, 7'd64, 7'd80};
	localparam logic [5:0] OFFS_TAB [8] = '{6'd40, 6'd0, 6'd20, 6'd0,
		6'd10, 6'd12, 6'd0, 6'd0};

	// Offset over gain is zero, one half or one quarter in every range.
	typedef enum logic [1:0] {
		OFS_NONE    = 2'd0,
		OFS_HALF    = 2'd1,
		OFS_QUARTER = 2'd2
	} ofs_code_t;

	localparam ofs_code_t OFS_TAB [8] = '{OFS_HALF, OFS_NONE, OFS_HALF, OFS_NONE,
		OFS_QUARTER, OFS_HALF, OFS_NONE, OFS_NONE};

	function automatic logic signed [15:0] offset_lsb_f(logic [2:0] rng, logic [4:0] n);
		logic [16:0] full;
		logic [16:0] mag;
		full = 17'd1 << n;
		case (OFS_TAB[rng])
			OFS_HALF:    mag = full >> 1;
			OFS_QUARTER: mag = full >> 2;
			default:     mag = 17'd0;
		endcase
		return 16'(17'd0 - mag);
	endfunction

	typedef struct packed {
		logic               cmd;
		logic [4:0]         n;
		logic [2:0]         rng;
		logic [6:0]         gain;
		logic [5:0]         offs;
		logic [11:0]        vref;
		logic signed [15:0] v;
		logic [15:0]        rb_code;
		logic signed [15:0] offset_lsb;
		logic [18:0]        x;
		logic [27:0]        p_v10;
		logic [34:0]        p_sc;
		logic [8:0]         v10;
		logic [14:0]        scale;
		logic [14:0]        den;
		logic [14:0]        ov;
		logic signed [34:0] sum;
		logic [30:0]        lim;
		logic [30:0]        prodrb;
		logic               neg;
		logic               ovf;
		logic [32:0]        rem;
		logic [15:0]        q;
		logic signed [15:0] rb_mv;
		logic [15:0]        dac;
		logic [15:0]        payload;
	} pipe_t;

endpackage
`default_nettype wire

FILE: hdl/dvc_if.sv
// Channel interfaces of the DAC voltage/code converter: request, result and
// configuration write. Depends on nothing.
`default_nettype none
interface dvc_in_if;
	logic               valid;
	logic               ready;
	logic               cmd;
	logic signed [15:0] target_mv;
	logic [15:0]        readback_word;
	modport source(output valid, cmd, target_mv, readback_word, input ready);
	modport sink(input valid, cmd, target_mv, readback_word, output ready);
endinterface

interface dvc_out_if;
	logic               valid;
	logic               ready;
	logic [15:0]        dac_code;
	logic [15:0]        write_payload;
	logic [15:0]        readback_code;
	logic signed [15:0] readback_mv;
	logic [14:0]        scale_num_mv;
	logic [4:0]         scale_pow2;
	logic signed [15:0] offset_lsb;
	modport source(output valid, dac_code, write_payload, readback_code, readback_mv,
		scale_num_mv, scale_pow2, offset_lsb, input ready);
	modport sink(input valid, dac_code, write_payload, readback_code, readback_mv,
		scale_num_mv, scale_pow2, offset_lsb, output ready);
endinterface

interface dvc_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [11:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: hdl/dac_voltage_code_converter_unit.sv
// DAC voltage/code converter, top level and whole datapath.
// Depends on dvc_pkg, the channel interfaces in dvc_if.sv and the macro header.
//
// Use: each word on in_ch is one conversion. cmd 0 turns target_mv into a
// clamped code and its left-justified write payload; cmd 1 right-justifies
// readback_word and turns it into millivolts. Every result word on out_ch also
// carries the scale numerator, scale exponent and offset in LSBs for the range.
// Registers (output range, reference, resolution) are written on cfg, which is
// always ready; write them only while no conversion is in flight.
// There are 23 register stages: six of scaling and multiplication, sixteen
// restoring-divider stages (one quotient bit each) and an output register.
// out_ch.valid rises once a word reaches the output register; the word is
// taken with out_ch ready. One word is accepted per cycle unless the stages are full.
// Each stage holds its word when the stage after it is full and stalled, so a
// stalled receiver fills the empty stages first and then drops in_ch.ready;
// nothing is lost or repeated. Reset empties the pipeline and loads output
// range 0, reference 2500 mV and resolution 16.
`default_nettype none
`include "dac_voltage_code_converter_unit_macros.svh"
module dac_voltage_code_converter_unit
	import dvc_pkg::*;
#(
	parameter int MAX_BITS = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	dvc_in_if.sink      in_ch,
	dvc_out_if.source   out_ch,
	dvc_cfg_if.sink     cfg
);

	logic [2:0]  range_q;
	logic [11:0] vref_q;
	logic [4:0]  res_q;
	logic [4:0]  eff_n;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_q <= 3'd0;
			vref_q  <= 12'd2500;
			res_q   <= 5'd16;
		end else if (cfg.valid) begin
			case (reg_idx_t'(cfg.index))
				REG_OUTPUT_RANGE: range_q <= cfg.data[2:0];
				REG_VREF_MV:      vref_q  <= cfg.data;
				REG_RES_BITS:     res_q   <= cfg.data[4:0];
				default:          ;
			endcase
		end
	end

	assign eff_n = (res_q == 5'd0 || 32'(res_q) > MAX_BITS) ? 5'(MAX_BITS) : res_q;

	logic [NUM_STAGES:1]   vld_s;
	logic [NUM_STAGES+1:1] rdy;
	pipe_t                 pipe_s [NUM_STAGES:1];
	pipe_t                 nx [NUM_STAGES:1];

	// A stage takes a new word when it is empty or its word moves on.
	always_comb begin
		rdy[NUM_STAGES+1] = out_ch.ready;
		for (int k = NUM_STAGES; k >= 1; k--) begin
			rdy[k] = !vld_s[k] || rdy[k+1];
		end
	end

	assign in_ch.ready = rdy[1];

	always_comb begin
		pipe_t       p;
		logic [12:0] r10;
		logic [18:0] r2;
		logic [14:0] sce;
		logic signed [34:0] base;
		logic [16:0] full;
		logic [15:0] dac;
		logic [29:0] dsh;

		// Stage 1: capture and table lookup, first multiplications.
		p = '0;
		p.cmd        = in_ch.cmd;
		p.n          = eff_n;
		p.rng        = range_q;
		p.gain       = GAIN_TAB[range_q];
		p.offs       = OFFS_TAB[range_q];
		p.vref       = vref_q;
		p.v          = in_ch.target_mv;
		p.rb_code    = in_ch.readback_word >> (5'd16 - eff_n);
		p.offset_lsb = offset_lsb_f(range_q, eff_n);
		p.x          = 19'(vref_q) * 19'(GAIN_TAB[range_q]);
		p.p_v10      = 28'(vref_q) * 28'(RECIP10);
		nx[1] = p;

		// Stage 2: estimate of vref/10, product for the scale estimate.
		p = pipe_s[1];
		p.v10  = p.p_v10[27:19];
		p.p_sc = 35'(p.x) * 35'(RECIP10);
		nx[2] = p;

		// Stage 3: both estimates may be one low; correct them.
		p = pipe_s[2];
		r10 = 13'(p.vref) - 13'(p.v10) * 13'd10;
		if (r10 >= 13'd10) begin
			p.v10 = p.v10 + 9'd1;
		end
		sce = p.p_sc[33:19];
		r2 = p.x - 19'(sce) * 19'd10;
		p.scale = (r2 >= 19'd10) ? sce + 15'd1 : sce;
		nx[3] = p;

		// Stage 4: divisor and offset in millivolts.
		p = pipe_s[3];
		p.den = 15'(16'(p.gain) * 16'(p.v10));
		p.ov  = 15'(15'(p.offs) * 15'(p.v10));
		nx[4] = p;

		// Stage 5: rounded numerator, clamp limit, readback product.
		p = pipe_s[4];
		base = 35'(p.v) + $signed({20'd0, p.ov});
		p.sum = (base <<< p.n) + $signed({20'd0, p.den >> 1});
		p.lim = 31'(p.den) << p.n;
		p.prodrb = 31'(p.rb_code) * 31'(p.den);
		nx[5] = p;

		// Stage 6: sign and clamp checks, readback voltage.
		p = pipe_s[5];
		p.neg = p.sum < 0;
		p.ovf = !p.neg && (p.sum >= $signed({4'd0, p.lim}));
		p.rem = p.sum[32:0];
		p.q   = '0;
		p.rb_mv = 16'(17'(p.prodrb >> p.n) - 17'(p.ov));
		nx[6] = p;

		// Divider: one restoring step per stage, most significant bit first.
		// Without clamping the quotient fits sixteen bits, so the steps are exact.
		for (int j = 0; j < DIV_STAGES; j++) begin
			p = pipe_s[FRONT_STAGES + j];
			dsh = 30'(p.den) << (DIV_STAGES - 1 - j);
			if (p.rem >= 33'(dsh)) begin
				p.rem = p.rem - 33'(dsh);
				p.q[DIV_STAGES - 1 - j] = 1'b1;
			end
			nx[FRONT_STAGES + 1 + j] = p;
		end

		// Output stage: clamp, justify and blank the unused side.
		p = pipe_s[NUM_STAGES - 1];
		full = 17'd1 << p.n;
		if (p.cmd || p.den == 15'd0 || p.neg) begin
			dac = 16'd0;
		end else if (p.ovf) begin
			dac = 16'(full - 17'd1);
		end else begin
			dac = p.q;
		end
		p.dac     = dac;
		p.payload = dac << (5'd16 - p.n);
		if (!p.cmd) begin
			p.rb_code = 16'd0;
			p.rb_mv   = 16'sd0;
		end
		nx[NUM_STAGES] = p;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (rdy[1]) begin
				vld_s[1] <= in_ch.valid;
			end
			for (int k = 2; k <= NUM_STAGES; k++) begin
				if (rdy[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 1; k <= NUM_STAGES; k++) begin
			if (rdy[k]) begin
				pipe_s[k] <= nx[k];
			end
		end
	end

	assign out_ch.valid         = vld_s[NUM_STAGES];
	assign out_ch.dac_code      = pipe_s[NUM_STAGES].dac;
	assign out_ch.write_payload = pipe_s[NUM_STAGES].payload;
	assign out_ch.readback_code = pipe_s[NUM_STAGES].rb_code;
	assign out_ch.readback_mv   = pipe_s[NUM_STAGES].rb_mv;
	assign out_ch.scale_num_mv  = pipe_s[NUM_STAGES].scale;
	assign out_ch.scale_pow2    = pipe_s[NUM_STAGES].n;
	assign out_ch.offset_lsb    = pipe_s[NUM_STAGES].offset_lsb;

	`DVC_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, in_ch.valid && in_ch.ready, vld_s[1])
	`DVC_ASSERT_NOW(a_code_side_blank, clk, arst_n, out_ch.valid && out_ch.readback_code != 16'd0, out_ch.dac_code == 16'd0 && out_ch.write_payload == 16'd0)
	`DVC_ASSERT_NOW(a_payload_justified, clk, arst_n, out_ch.valid, out_ch.write_payload == 16'(out_ch.dac_code << (5'd16 - out_ch.scale_pow2)))
	`DVC_ASSERT_NOW(a_pow2_range, clk, arst_n, out_ch.valid, out_ch.scale_pow2 != 5'd0 && 32'(out_ch.scale_pow2) <= MAX_BITS)

endmodule
`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench of the DAC voltage/code converter.
// Needs dvc_pkg, the channel interfaces and dac_voltage_code_converter_unit.
`timescale 1ns / 100ps
module testbench;
	import dvc_pkg::*;

	typedef struct packed {
		logic [15:0]        dac_code;
		logic [15:0]        write_payload;
		logic [15:0]        readback_code;
		logic signed [15:0] readback_mv;
		logic [14:0]        scale_num_mv;
		logic [4:0]         scale_pow2;
		logic signed [15:0] offset_lsb;
	} conv_word_t;

	class conversion_scoreboard;
		logic [2:0]  out_range;
		logic [11:0] vref;
		logic [4:0]  res_bits;
		conv_word_t  expected_words[$];
		int          checked;

		function new();
			out_range = 3'd0;
			vref = 12'd2500;
			res_bits = 5'd16;
			checked = 0;
		endfunction

		function void set_register(reg_idx_t idx, logic [11:0] value);
			case (idx)
				REG_OUTPUT_RANGE: out_range = value[2:0];
				REG_VREF_MV:      vref = value;
				REG_RES_BITS:     res_bits = value[4:0];
				default: ;
			endcase
		endfunction

		function conv_word_t convert(logic cmd, logic signed [15:0] target,
				logic [15:0] word);
			conv_word_t r;
			longint gain, offs, n, full, v10, den, num, sum, code, prod;
			gain = longint'(GAIN_TAB[out_range]);
			offs = longint'(OFS_TAB[out_range] == OFS_NONE ? 0 : OFFS_TAB[out_range]);
			offs = longint'(OFFS_TAB[out_range]);
			n = longint'(res_bits);
			if (n == 0 || n > 16) n = 16;
			full = longint'(1) << n;
			v10 = longint'(vref) / 10;
			r = '0;
			if (cmd == 1'b0) begin
				den = gain * v10;
				if (den > 0) begin
					num = (longint'(target) + offs * v10) * full;
					sum = num + den / 2;
					code = (sum < 0) ? 0 : sum / den;
					if (code > full - 1) code = full - 1;
					r.dac_code = code[15:0];
					r.write_payload = 16'(code << (16 - n));
				end
			end else begin
				r.readback_code = word >> (16 - n);
				prod = longint'(r.readback_code) * gain * v10;
				r.readback_mv = 16'(prod / full - offs * v10);
			end
			r.scale_num_mv = 15'((longint'(vref) * gain) / 10);
			r.scale_pow2 = n[4:0];
			r.offset_lsb = 16'(-((full * offs) / gain));
			return r;
		endfunction

		function void note_request(logic cmd, logic signed [15:0] target,
				logic [15:0] word);
			expected_words.push_back(convert(cmd, target, word));
		endfunction

		// Returns an empty string when the word matches the oldest expectation.
		function string check_result(conv_word_t got);
			conv_word_t e;
			string msg;
			msg = "";
			if (expected_words.size() == 0) return "result word with nothing expected";
			e = expected_words.pop_front();
			checked++;
			if (got.dac_code !== e.dac_code)
				msg = {msg, $sformatf(" dac_code %0d/%0d", got.dac_code, e.dac_code)};
			if (got.write_payload !== e.write_payload)
				msg = {msg, $sformatf(" write_payload %h/%h", got.write_payload,
					e.write_payload)};
			if (got.readback_code !== e.readback_code)
				msg = {msg, $sformatf(" readback_code %0d/%0d", got.readback_code,
					e.readback_code)};
			if (got.readback_mv !== e.readback_mv)
				msg = {msg, $sformatf(" readback_mv %0d/%0d", got.readback_mv,
					e.readback_mv)};
			if (got.scale_num_mv !== e.scale_num_mv)
				msg = {msg, $sformatf(" scale_num_mv %0d/%0d", got.scale_num_mv,
					e.scale_num_mv)};
			if (got.scale_pow2 !== e.scale_pow2)
				msg = {msg, $sformatf(" scale_pow2 %0d/%0d", got.scale_pow2, e.scale_pow2)};
			if (got.offset_lsb !== e.offset_lsb)
				msg = {msg, $sformatf(" offset_lsb %0d/%0d", got.offset_lsb, e.offset_lsb)};
			return msg;
		endfunction
	endclass

	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	dvc_in_if  in_ch();
	dvc_out_if out_ch();
	dvc_cfg_if cfg();

	dac_voltage_code_converter_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source),
		.cfg    (cfg.sink)
	);

	conversion_scoreboard sb = new();
	int errors = 0;
	int cycles = 0;
	int snd_idle_pct = 0;
	int rcv_idle_pct = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int sent = 0;

	always #5 clk = ~clk;

	initial begin
		in_ch.valid = 1'b0;
		in_ch.cmd = 1'b0;
		in_ch.target_mv = '0;
		in_ch.readback_word = '0;
		out_ch.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
	end

	task automatic report(string msg);
		$display("mismatch at cycle %0d:%s", cycles, msg);
		errors++;
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("testbench: errors");
			$finish;
		end
	end

	// Receiver: checks every accepted word and decides ready for the next edge.
	always @(posedge clk) begin
		string msg;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				msg = sb.check_result('{out_ch.dac_code, out_ch.write_payload,
					out_ch.readback_code, out_ch.readback_mv, out_ch.scale_num_mv,
					out_ch.scale_pow2, out_ch.offset_lsb});
				if (msg != "") report(msg);
			end
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
			end
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [11:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		sb.set_register(idx, value);
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_ranges(logic [2:0] rng, logic [11:0] vref, logic [4:0] res);
		write_reg(REG_OUTPUT_RANGE, {9'd0, rng});
		write_reg(REG_VREF_MV, vref);
		write_reg(REG_RES_BITS, {7'd0, res});
	endtask

	task automatic send(logic cmd, logic signed [15:0] target, logic [15:0] word);
		while ($urandom_range(99) < snd_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.cmd <= cmd;
		in_ch.target_mv <= target;
		in_ch.readback_word <= word;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		sb.note_request(cmd, target, word);
		sent++;
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_words.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic send_random();
		logic signed [15:0] t;
		case ($urandom_range(3))
			0: t = 16'($urandom);
			1: t = 16'(int'($urandom_range(36000)) - 12000);
			2: t = 16'(int'($urandom_range(400)) - 200);
			default: t = 16'(int'($urandom_range(2000)) + 9000);
		endcase
		send(1'($urandom), t, 16'($urandom));
	endtask

	logic [2:0]  ph_rng [8] = '{3'd7, 3'd3, 3'd5, 3'd2, 3'd4, 3'd1, 3'd6, 3'd0};
	logic [11:0] ph_vref [8] = '{12'd2000, 12'd3000, 12'd5, 12'd4095, 12'd9,
		12'd10, 12'd0, 12'd2500};
	logic [4:0]  ph_res [8] = '{5'd1, 5'd12, 5'd0, 5'd31, 5'd17, 5'd16, 5'd8, 5'd15};

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words at the reset settings, then under a degenerate reference,
		// out-of-range resolutions and a one-bit resolution.
		rcv_idle_pct = 0;
		send(1'b0, -16'sd32768, 16'h0000);
		send(1'b0, 16'sd32767, 16'hFFFF);
		send(1'b0, 16'sd0, 16'h0000);
		send(1'b0, -16'sd1, 16'h0000);
		send(1'b0, -16'sd12000, 16'h0000);
		send(1'b0, 16'sd3999, 16'h0000);
		send(1'b0, 16'sd4000, 16'h0000);
		send(1'b1, 16'sd0, 16'h0000);
		send(1'b1, 16'sd0, 16'hFFFF);
		send(1'b1, 16'sd0, 16'h8000);
		send(1'b1, -16'sd1, 16'h0001);
		drain();
		set_ranges(3'd0, 12'd5, 5'd0);
		send(1'b0, 16'sd1000, 16'h0000);
		send(1'b1, 16'sd0, 16'hFFFF);
		drain();
		set_ranges(3'd5, 12'd4095, 5'd31);
		send(1'b0, 16'sd32767, 16'h0000);
		send(1'b0, -16'sd32768, 16'h0000);
		send(1'b1, 16'sd0, 16'hFFFF);
		drain();
		set_ranges(3'd7, 12'd2000, 5'd1);
		send(1'b0, 16'sd8000, 16'h0000);
		send(1'b0, 16'sd7999, 16'h0000);
		send(1'b1, 16'sd0, 16'h8000);
		drain();

		for (int ph = 0; ph < 12; ph++) begin
			snd_idle_pct = (ph < 4) ? 19 : (ph < 8) ? 54 : 0;
			rcv_idle_pct = (ph < 4) ? 54 : (ph < 8) ? 19 : 0;
			if (ph < 8)
				set_ranges(ph_rng[ph], ph_vref[ph], ph_res[ph]);
			else
				set_ranges(3'($urandom), 12'(2000 + $urandom_range(1000)),
					5'($urandom_range(1, 16)));
			for (int k = 0; k < 58; k++) begin
				// Long receiver stall while words keep coming fills the pipeline.
				if (ph == 9 && k == 10) hold_req++;
				send_random();
			end
			drain();
		end

		$display("%0d conversions sent, %0d result words checked", sent, sb.checked);
		$display("covered all eight ranges, references 0 to 4095 mV, resolutions 0 to 31");
		if (errors == 0 && sb.expected_words.size() == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end
endmodule
